### src/brs_pkg.sv
// Shared types, constants and helpers for the binary row shear block.
// Used by brs_ctrl, brs_dpath and binary_row_shear_core.
package brs_pkg;

    localparam int WORD_PIXELS    = 64;
    localparam int MAX_ROW_PIXELS = 4096;
    localparam int ROW_WORDS      = (MAX_ROW_PIXELS + WORD_PIXELS - 1) / WORD_PIXELS;
    localparam int ADDR_W         = $clog2(ROW_WORDS);
    localparam int CNT_W          = $clog2(ROW_WORDS + 1);
    localparam int ACC_W          = 40;
    localparam int FRAC_BITS      = 20;
    localparam int SLOPE_W        = 18;
    localparam int ORIGIN_W       = 17;
    localparam int WIDTH_W        = 13;
    localparam int CFG_DATA_W     = 18;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd3;

    typedef struct packed {
        logic take_in;
        logic load_acc;
        logic calc_shift;
        logic rd_hi;
        logic latch_hi;
        logic capture;
        logic next_word;
        logic end_row;
    } brs_cmd_t;

    typedef struct packed {
        logic last_word;
    } brs_sts_t;

    // Top 'count' pixels set, MSB first; count runs 0..64.
    function automatic logic [WORD_PIXELS-1:0] pix_mask(input logic [CNT_W-1:0] count);
        logic [WORD_PIXELS-1:0] m;
        m = '1;
        if (count >= CNT_W'(WORD_PIXELS)) begin
            pix_mask = '1;
        end else begin
            pix_mask = ~(m >> count);
        end
    endfunction

    function automatic logic [WORD_PIXELS-1:0] fill_bg(input logic [WORD_PIXELS-1:0] data,
                                                       input logic [WORD_PIXELS-1:0] m,
                                                       input logic bg);
        fill_bg = (data & m) | ({WORD_PIXELS{bg}} & ~m);
    endfunction

endpackage

### src/brs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module brs_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/brs_ctrl.sv
// Sequencer for the binary row shear block: takes words, then walks the output row.
// Depends on brs_pkg.
module brs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_row_end,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  brs_pkg::brs_sts_t sts,
    output brs_pkg::brs_cmd_t cmd
);
    import brs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_RDHI  = 3'd3;
    localparam logic [2:0] ST_RDLO  = 3'd4;
    localparam logic [2:0] ST_CAPT  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take_in = 1'b1;
                    if (s_row_end) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load_acc = 1'b1;
                state_next   = ST_SHIFT;
            end
            ST_SHIFT: begin
                cmd.calc_shift = 1'b1;
                state_next     = ST_RDHI;
            end
            ST_RDHI: begin
                cmd.rd_hi  = 1'b1;
                state_next = ST_RDLO;
            end
            ST_RDLO: begin
                cmd.latch_hi = 1'b1;
                state_next   = ST_CAPT;
            end
            ST_CAPT: begin
                cmd.capture = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (sts.last_word) begin
                        cmd.end_row = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        cmd.next_word = 1'b1;
                        state_next    = ST_RDHI;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

### src/brs_dpath.sv
// Datapath of the binary row shear block: row store, shift accumulator,
// word alignment and fill. Depends on brs_pkg and brs_ram.
module brs_dpath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [brs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [brs_pkg::WORD_PIXELS-1:0]   s_pixel_word,
    input  logic                              s_frame_end,
    output logic [brs_pkg::WORD_PIXELS-1:0]   m_sheared_word,
    output logic                              m_row_last,
    output logic                              m_frame_last,
    input  brs_pkg::brs_cmd_t                 cmd,
    output brs_pkg::brs_sts_t                 sts
);
    import brs_pkg::*;

    localparam int Q_W    = ACC_W - FRAC_BITS - ADDR_W;
    localparam int BASE_W = Q_W + 2;
    localparam int N_W    = WIDTH_W + 1;

    logic signed [SLOPE_W-1:0]  slope_reg;
    logic signed [ORIGIN_W-1:0] origin_reg;
    logic [WIDTH_W-1:0]         width_reg;
    logic                       bg_reg;

    logic [CNT_W-1:0]           count_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       fstart_reg;
    logic                       final_reg;
    logic signed [Q_W-1:0]      q_reg;
    logic [ADDR_W-1:0]          r_reg;
    logic [ADDR_W-1:0]          k_reg;
    logic [WORD_PIXELS-1:0]     hi_reg;

    logic [WORD_PIXELS-1:0]     rd_data;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       wr_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slope_reg  <= '0;
            origin_reg <= '0;
            width_reg  <= WIDTH_W'(MAX_ROW_PIXELS);
            bg_reg     <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SLOPE:  slope_reg  <= cfg_wdata[SLOPE_W-1:0];
                REG_ORIGIN: origin_reg <= cfg_wdata[ORIGIN_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_wdata[WIDTH_W-1:0];
                REG_BG:     bg_reg     <= cfg_wdata[0];
                default:    bg_reg     <= bg_reg;
            endcase
        end
    end

    // effective row width and words per row
    logic [WIDTH_W-1:0] w_eff;
    logic [CNT_W-1:0]   nwords;
    always_comb begin
        if (width_reg == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (width_reg > WIDTH_W'(MAX_ROW_PIXELS)) begin
            w_eff = WIDTH_W'(MAX_ROW_PIXELS);
        end else begin
            w_eff = width_reg;
        end
    end
    assign nwords        = CNT_W'((w_eff + WIDTH_W'(WORD_PIXELS - 1)) >> ADDR_W);
    assign sts.last_word = ({1'b0, k_reg} == nwords - CNT_W'(1));

    // row store
    assign wr_en = cmd.take_in && (count_reg < CNT_W'(ROW_WORDS));

    logic signed [BASE_W-1:0] j_lo, j_hi, j_sel;
    assign j_lo = $signed({{(BASE_W-ADDR_W){1'b0}}, k_reg}) - BASE_W'(q_reg);
    assign j_hi = j_lo - BASE_W'(1);
    assign rd_addr = cmd.rd_hi ? j_hi[ADDR_W-1:0] : j_lo[ADDR_W-1:0];
    assign j_sel   = cmd.latch_hi ? j_hi : j_lo;

    brs_ram #(.DATA_W(WORD_PIXELS), .DEPTH(ROW_WORDS)) u_row_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (s_pixel_word),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // source word as seen after width and fill-count masking
    logic                   src_ok;
    logic signed [N_W-1:0]  src_n;
    logic [CNT_W-1:0]       src_cnt;
    logic [WORD_PIXELS-1:0] src_word;
    always_comb begin
        src_ok = !j_sel[BASE_W-1] && (j_sel < $signed({{(BASE_W-CNT_W){1'b0}}, count_reg}));
        src_n  = $signed({1'b0, w_eff}) - $signed({1'b0, j_sel[ADDR_W-1:0], {ADDR_W{1'b0}}});
        if (!src_ok || src_n <= 0) begin
            src_cnt = '0;
        end else if (src_n >= N_W'(WORD_PIXELS)) begin
            src_cnt = CNT_W'(WORD_PIXELS);
        end else begin
            src_cnt = src_n[CNT_W-1:0];
        end
        src_word = fill_bg(rd_data, pix_mask(src_cnt), bg_reg);
    end

    // output word
    logic [2*WORD_PIXELS-1:0] cat;
    logic signed [N_W-1:0]    out_n;
    logic [CNT_W-1:0]         out_cnt;
    logic [WORD_PIXELS-1:0]   out_word;
    always_comb begin
        cat   = {hi_reg, src_word} >> r_reg;
        out_n = $signed({1'b0, w_eff}) - $signed({1'b0, k_reg, {ADDR_W{1'b0}}});
        if (out_n >= N_W'(WORD_PIXELS)) begin
            out_cnt = CNT_W'(WORD_PIXELS);
        end else begin
            out_cnt = out_n[CNT_W-1:0];
        end
        out_word = fill_bg(cat[WORD_PIXELS-1:0], pix_mask(out_cnt), bg_reg);
    end

    // accumulator
    logic signed [SLOPE_W-1:0]         diff;
    logic signed [SLOPE_W+SLOPE_W-1:0] prod;
    assign diff = SLOPE_W'(8) - SLOPE_W'(origin_reg);
    assign prod = slope_reg * diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            acc_reg    <= '0;
            fstart_reg <= 1'b1;
            final_reg  <= 1'b0;
            k_reg      <= '0;
        end else begin
            if (cmd.take_in) begin
                if (wr_en) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                if (s_frame_end) begin
                    final_reg <= 1'b1;
                end
            end
            if (cmd.load_acc && fstart_reg) begin
                acc_reg <= ACC_W'(prod) + (ACC_W'(1) <<< (FRAC_BITS - 1));
            end
            if (cmd.next_word) begin
                k_reg <= k_reg + ADDR_W'(1);
            end
            if (cmd.end_row) begin
                acc_reg    <= acc_reg + (ACC_W'(slope_reg) <<< 4);
                fstart_reg <= final_reg;
                final_reg  <= 1'b0;
                count_reg  <= '0;
                k_reg      <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_shift) begin
            q_reg <= acc_reg[ACC_W-1:FRAC_BITS+ADDR_W];
            r_reg <= acc_reg[FRAC_BITS+ADDR_W-1:FRAC_BITS];
        end
        if (cmd.latch_hi) begin
            hi_reg <= src_word;
        end
        if (cmd.capture) begin
            m_sheared_word <= out_word;
            m_row_last     <= sts.last_word;
            m_frame_last   <= sts.last_word && final_reg;
        end
    end
endmodule

### src/binary_row_shear_core.sv
// Top level of the binary row shear block.
// Depends on brs_pkg, brs_ctrl, brs_dpath, brs_ram.
//
// Takes a 1-bpp image in 64-pixel words, one row at a time, and on a row's last
// word emits that row shifted by floor(0.5 + shear*(y + 0.5 - origin)) with
// vacated and padding pixels set to the background bit. Input words are taken
// while idle; a row end passes through accumulator load and shift setup, then
// each output word takes two reads of the row store's one read port plus alignment
// and waits for m_ready. The input is not ready while a row is being emitted.
// Write configuration only while the block is idle.
module binary_row_shear_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [brs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [brs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [brs_pkg::WORD_PIXELS-1:0]  s_pixel_word,
    input  logic                             s_row_end,
    input  logic                             s_frame_end,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [brs_pkg::WORD_PIXELS-1:0]  m_sheared_word,
    output logic                             m_row_last,
    output logic                             m_frame_last
);
    import brs_pkg::*;

    brs_cmd_t cmd;
    brs_sts_t sts;

    brs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_row_end (s_row_end),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    brs_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_pixel_word   (s_pixel_word),
        .s_frame_end    (s_frame_end),
        .m_sheared_word (m_sheared_word),
        .m_row_last     (m_row_last),
        .m_frame_last   (m_frame_last),
        .cmd            (cmd),
        .sts            (sts)
    );
endmodule

### test/tb_binary_row_shear_core.sv
// Self-checking testbench for binary_row_shear_core: streams rows of 1-bpp words,
// predicts each sheared output row and checks every output item field by field.
// Depends on brs_pkg and the binary_row_shear_core RTL.
`timescale 1ns / 100ps

module tb_binary_row_shear_core;
    import brs_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [63:0] word;
        logic        row_end;
        logic        frame_end;
    } pix_item_t;

    typedef struct {
        logic [63:0] word;
        logic        row_last;
        logic        frame_last;
    } shear_item_t;

    // directed row: words, frame end flag, optional typed-in expectation of first word
    typedef struct {
        int          nwords;
        logic [63:0] fill;
        logic        frame_end;
        logic        has_exp;
        logic [63:0] exp_word;
    } row_vec_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [63:0] s_pixel_word = '0;
    logic s_row_end = 1'b0;
    logic s_frame_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [63:0] m_sheared_word;
    logic m_row_last;
    logic m_frame_last;

    binary_row_shear_core dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    logic [17:0] slope_q;
    logic [16:0] origin_q;
    logic [12:0] width_q;
    logic        bg_q;
    logic [63:0] row_buf [ROW_WORDS];
    int          words_held;
    logic [39:0] acc_q;
    logic        at_frame_start;
    logic        final_pending;

    shear_item_t sheared_q[$];
    int  errors = 0;
    int  cycles = 0;
    int  idle_pct = 26;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    function automatic logic src_bit(input longint xs, input longint w);
        int idx;
        if (xs < 0 || xs >= w) return bg_q;
        idx = int'(xs / 64);
        if (idx >= words_held) return bg_q;
        return row_buf[idx][63 - int'(xs % 64)];
    endfunction

    task automatic predict_shear(input pix_item_t it);
        longint slope, origin, w, sh, a, x;
        int nw;
        shear_item_t r;
        slope = longint'($signed(slope_q));
        if (words_held < ROW_WORDS) begin
            row_buf[words_held] = it.word;
            words_held++;
        end
        if (it.frame_end) final_pending = 1'b1;
        if (!it.row_end) return;
        if (at_frame_start) begin
            origin = longint'($signed(origin_q));
            acc_q = 40'(64'd524288 + 64'(slope * (8 - origin)));
        end
        w = width_q;
        if (w < 1) w = 1;
        if (w > MAX_ROW_PIXELS) w = MAX_ROW_PIXELS;
        a = longint'($signed(acc_q));
        sh = a >>> 20;
        nw = int'((w + 63) / 64);
        for (int k = 0; k < nw; k++) begin
            for (int b = 0; b < 64; b++) begin
                x = longint'(k) * 64 + b;
                r.word[63 - b] = (x >= w) ? bg_q : src_bit(x - sh, w);
            end
            r.row_last = (k == nw - 1);
            r.frame_last = (k == nw - 1) && final_pending;
            sheared_q.push_back(r);
        end
        acc_q = acc_q + 40'(slope * 16);
        at_frame_start = final_pending;
        final_pending = 1'b0;
        words_held = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SLOPE:  slope_q = val[17:0];
            REG_ORIGIN: origin_q = val[16:0];
            REG_WIDTH:  width_q = val[12:0];
            default:    bg_q = val[0];
        endcase
    endtask

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_item(input pix_item_t it);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_word <= it.word;
        s_row_end <= it.row_end;
        s_frame_end <= it.frame_end;
        do @(posedge aclk); while (!s_ready);
        predict_shear(it);
        @(negedge aclk);
    endtask

    task automatic send_row(input int nw, input logic fe, input logic [63:0] fill, input bit rnd);
        pix_item_t it;
        for (int i = 0; i < nw; i++) begin
            it.word = rnd ? {$urandom, $urandom} : fill;
            it.row_end = (i == nw - 1);
            it.frame_end = fe && (i == nw - 1 || $urandom_range(3) == 0);
            send_item(it);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sheared_q.size() != 0 && cycles < CYCLE_LIMIT) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        shear_item_t e;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (sheared_q.size() == 0) begin
                report("unexpected item", m_sheared_word, 64'd0);
            end else begin
                e = sheared_q.pop_front();
                if (m_sheared_word !== e.word) report("sheared_word", m_sheared_word, e.word);
                if (m_row_last !== e.row_last)
                    report("row_last", 64'(m_row_last), 64'(e.row_last));
                if (m_frame_last !== e.frame_last)
                    report("frame_last", 64'(m_frame_last), 64'(e.frame_last));
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycles);
            $display("** binary_row_shear_core: FAILED **");
            $finish;
        end
    end

    row_vec_t dir_rows[4] = '{
        '{1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'd0},
        '{2, 64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'd0},
        '{1, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 64'd0},
        '{3, 64'hA5A5_5A5A_F0F0_0F0F, 1'b1, 1'b0, 64'd0}
    };

    initial begin
        pix_item_t it;
        int nw, rows;
        slope_q = '0; origin_q = '0; width_q = 13'd4096; bg_q = 1'b0;
        words_held = 0; acc_q = '0; at_frame_start = 1'b1; final_pending = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // width 64 with zero slope: first word of each row passes unchanged
        write_reg(REG_WIDTH, 18'd64);
        foreach (dir_rows[i]) send_row(dir_rows[i].nwords, dir_rows[i].frame_end,
                                       dir_rows[i].fill, 1'b0);
        drain();
        // extremes: max positive slope, min origin, width 1, black fill
        write_reg(REG_SLOPE, 18'h1FFFF);
        write_reg(REG_ORIGIN, 18'h10000);
        write_reg(REG_WIDTH, 18'd1);
        write_reg(REG_BG, 18'd1);
        send_row(1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_row(1, 1'b1, 64'h0, 1'b0);
        drain();
        // most negative slope, max origin, width 0 acts as 1, then above max
        write_reg(REG_SLOPE, 18'h20000);
        write_reg(REG_ORIGIN, 18'h0FFFF);
        write_reg(REG_WIDTH, 18'd0);
        write_reg(REG_BG, 18'd0);
        send_row(2, 1'b1, 64'hDEAD_BEEF_0000_FFFF, 1'b0);
        drain();
        write_reg(REG_WIDTH, 18'h1FFF);
        write_reg(REG_SLOPE, 18'd3000);
        write_reg(REG_ORIGIN, 18'd0);
        send_row(70, 1'b0, 64'h0, 1'b1);  // overlong row: extra words dropped
        send_row(1, 1'b1, 64'h0, 1'b1);   // short row
        drain();

        // random phases; small widths mostly
        for (int ph = 0; ph < 8; ph++) begin
            idle_pct = (ph == 3) ? 0 : 26;
            write_reg(REG_SLOPE, (ph % 2) ? 18'($urandom)
                                          : 18'($signed($urandom_range(0, 40000)) - 20000));
            write_reg(REG_ORIGIN, (ph == 5) ? 18'($urandom) : 18'($urandom_range(0, 400)));
            write_reg(REG_WIDTH, (ph == 7) ? 18'd4096 : 18'($urandom_range(1, 200)));
            write_reg(REG_BG, 18'($urandom_range(1)));
            rows = (ph == 7) ? 1 : 15;
            for (int r = 0; r < rows; r++) begin
                nw = (ph == 7) ? 64 : (($urandom_range(9) == 0) ? $urandom_range(1, 6)
                                        : (int'(width_q) + 63) / 64);
                send_row(nw, ($urandom_range(4) == 0), 64'h0, 1'b1);
                if (ph == 2 && r == 5) drain();
            end
            drain();
        end

        if (errors == 0 && sheared_q.size() == 0) begin
            $display("** binary_row_shear_core: PASSED **");
        end else begin
            $display("** binary_row_shear_core: FAILED **");
        end
        $finish;
    end
endmodule

### filelist.f
src/brs_pkg.sv
src/brs_ram.sv
src/brs_ctrl.sv
src/brs_dpath.sv
src/binary_row_shear_core.sv
test/tb_binary_row_shear_core.sv
